// ----- sv/vtpp_pkg.sv -----
// Shared types, constants and helper functions of the test pattern pixel generator.
package vtpp_pkg;

    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned REM_W         = 12;
    localparam int unsigned REM_STAGES    = 6;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THICK  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [7:0]  t;
        logic [12:0] w;
        logic [12:0] h;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] rad;
        logic [10:0] grid;
    } geom_t;

    typedef struct packed {
        logic       border;
        logic       in_inner;
        logic       in_disk;
        logic [2:0] sel;
    } cls_t;

    localparam rgb_t COLOR_WHITE   = '{8'd255, 8'd255, 8'd255};
    localparam rgb_t COLOR_YELLOW  = '{8'd255, 8'd255, 8'd0};
    localparam rgb_t COLOR_CYAN    = '{8'd0,   8'd255, 8'd255};
    localparam rgb_t COLOR_GREEN   = '{8'd0,   8'd255, 8'd0};
    localparam rgb_t COLOR_MAGENTA = '{8'd255, 8'd0,   8'd255};
    localparam rgb_t COLOR_RED     = '{8'd255, 8'd0,   8'd0};
    localparam rgb_t COLOR_BLUE    = '{8'd0,   8'd0,   8'd255};
    localparam rgb_t COLOR_BLACK   = '{8'd0,   8'd0,   8'd0};
    localparam rgb_t COLOR_GREY    = '{8'd127, 8'd127, 8'd127};

    function automatic rgb_t stripe_color(input logic [2:0] sel);
        rgb_t c;
        case (sel)
            3'd0:    c = COLOR_WHITE;
            3'd1:    c = COLOR_YELLOW;
            3'd2:    c = COLOR_CYAN;
            3'd3:    c = COLOR_GREEN;
            3'd4:    c = COLOR_MAGENTA;
            3'd5:    c = COLOR_RED;
            3'd6:    c = COLOR_BLUE;
            default: c = COLOR_BLACK;
        endcase
        return c;
    endfunction

    // one restoring step: returns {quotient bit, new partial remainder}
    function automatic logic [16:0] div_step(input logic [15:0] n, input logic [12:0] d,
                                             input logic [1:0] sh);
        logic [15:0] sd;
        sd = {3'b000, d} << sh;
        if (n >= sd)
            return {1'b1, n - sd};
        else
            return {1'b0, n};
    endfunction

    function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r,
                                                  input logic [10:0] d,
                                                  input logic [3:0] sh);
        logic [23:0] sd;
        sd = {13'd0, d} << sh;
        if ({12'd0, r} >= sd)
            return r - sd[REM_W-1:0];
        else
            return r;
    endfunction

endpackage

// ----- sv/vtpp_cfg.sv -----
// Configuration registers and derived frame geometry.
module vtpp_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [12:0]           cfg_data,
    output vtpp_pkg::geom_t       geom
);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [7:0]  thick_reg;
    logic [12:0] w_lim;
    logic [12:0] h_lim;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [11:0] rad;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            thick_reg  <= 8'd4;
        end
        else if (cfg_valid)
        begin
            case (vtpp_pkg::cfg_index_t'(cfg_index))
                vtpp_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                vtpp_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                vtpp_pkg::CFG_THICK:  thick_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_lim = (32'(width_reg) > vtpp_pkg::MAX_DIMENSION) ?
                13'(vtpp_pkg::MAX_DIMENSION) : width_reg;
        h_lim = (32'(height_reg) > vtpp_pkg::MAX_DIMENSION) ?
                13'(vtpp_pkg::MAX_DIMENSION) : height_reg;
        cx    = w_lim[12:1];
        cy    = h_lim[12:1];
        rad   = (cx > cy) ? cy : cx;
        geom.t    = thick_reg;
        geom.w    = w_lim;
        geom.h    = h_lim;
        geom.cx   = cx;
        geom.cy   = cy;
        geom.rad  = rad;
        geom.grid = rad[11:1];
    end

endmodule

// ----- sv/vtpp_rem.sv -----
// Pipelined restoring remainder unit, two steps per stage.
module vtpp_rem (
    input  logic                            clk,
    input  logic [vtpp_pkg::REM_STAGES-1:0] en,
    input  logic [vtpp_pkg::REM_W-1:0]      dividend,
    input  logic [10:0]                     divisor,
    output logic [vtpp_pkg::REM_W-1:0]      rem
);

    logic [vtpp_pkg::REM_W-1:0] rem_reg [vtpp_pkg::REM_STAGES];

    for (genvar k = 0; k < vtpp_pkg::REM_STAGES; k++)
    begin : g_stage
        localparam int unsigned SH_HI = vtpp_pkg::REM_W - 1 - 2 * k;
        logic [vtpp_pkg::REM_W-1:0] rem_in;
        logic [vtpp_pkg::REM_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
        end

        always_comb
        begin
            rem_next = vtpp_pkg::rem_step(
                vtpp_pkg::rem_step(rem_in, divisor, 4'(SH_HI)), divisor, 4'(SH_HI - 1));
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
                rem_reg[k] <= rem_next;
        end
    end

    assign rem = rem_reg[vtpp_pkg::REM_STAGES-1];

endmodule

// ----- sv/video_test_pattern_pixel_top.sv -----
// Test pattern pixel generator: eight-stage pipeline from coordinate to RGB.
// Throughput: one beat per cycle while the output is not stalled.
// The depth is set by the 12-step grid remainder, two steps per stage.
// Stalls collapse bubbles stage by stage; input is taken while a result waits if a bubble lies ahead.
// Reset clears all valid bits and loads 640 x 480 with thickness 4.
module video_test_pattern_pixel_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int unsigned NSTG = 8;

    vtpp_pkg::geom_t geom;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    // stage 0
    logic               border0_reg;
    logic signed [13:0] dx0_reg;
    logic signed [13:0] dy0_reg;
    logic [11:0]        adx0_reg;
    logic [11:0]        ady0_reg;
    logic [15:0]        num0_reg;
    logic               border0_next;
    logic signed [13:0] dx0_next;
    logic signed [13:0] dy0_next;
    logic [11:0]        adx0_next;
    logic [11:0]        ady0_next;
    logic [15:0]        num0_next;
    logic               xlt;
    logic               ylt;
    logic [13:0]        ndx;
    logic [13:0]        ndy;
    logic [15:0]        nsum;

    // stage 1
    logic               border1_reg;
    logic [23:0]        dx2_reg;
    logic [23:0]        dy2_reg;
    logic [23:0]        rr_reg;
    logic [23:0]        ii_reg;
    logic [15:0]        n1_reg;
    logic               q2_reg;
    logic signed [13:0] inner;
    logic signed [27:0] pdx;
    logic signed [27:0] pdy;
    logic signed [27:0] pii;
    logic [16:0]        ds1;
    logic [12:0]        dvs;

    // stage 2
    logic               border2_reg;
    logic               in_inner2_reg;
    logic               in_disk2_reg;
    logic [15:0]        n2_reg;
    logic [1:0]         q21_reg;
    logic [24:0]        d2;
    logic [16:0]        ds2;
    logic [16:0]        ds3;

    // stages 3..6
    vtpp_pkg::cls_t     cls_reg [3:6];
    vtpp_pkg::cls_t     cls3_next;

    logic [11:0]        remx;
    logic [11:0]        remy;
    logic               grid_hit;
    vtpp_pkg::rgb_t     color_next;
    vtpp_pkg::rgb_t     color_reg;

    vtpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NSTG; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 0: border test, signed and absolute offsets from center, stripe numerator
    always_comb
    begin
        border0_next = (pixel_x < {4'd0, geom.t}) || (pixel_y < {4'd0, geom.t}) ||
                       (({1'b0, pixel_x} + {5'd0, geom.t}) >= geom.w) ||
                       (({1'b0, pixel_y} + {5'd0, geom.t}) >= geom.h);
        xlt       = pixel_x < geom.cx;
        ylt       = pixel_y < geom.cy;
        dx0_next  = $signed({2'b00, pixel_x}) - $signed({2'b00, geom.cx}) +
                    $signed({13'd0, xlt});
        dy0_next  = $signed({2'b00, pixel_y}) - $signed({2'b00, geom.cy}) +
                    $signed({13'd0, ylt});
        ndx       = 14'(-dx0_next);
        ndy       = 14'(-dy0_next);
        adx0_next = dx0_next[13] ? ndx[11:0] : dx0_next[11:0];
        ady0_next = dy0_next[13] ? ndy[11:0] : dy0_next[11:0];
        nsum      = {{2{dx0_next[13]}}, dx0_next} + {4'd0, geom.rad} + {15'd0, !xlt};
        num0_next = {nsum[13:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            border0_reg <= border0_next;
            dx0_reg     <= dx0_next;
            dy0_reg     <= dy0_next;
            adx0_reg    <= adx0_next;
            ady0_reg    <= ady0_next;
            num0_reg    <= num0_next;
        end
    end

    // stage 1: squares, first quotient bit
    always_comb
    begin
        inner = $signed({2'b00, geom.rad}) - $signed({5'd0, geom.t, 1'b0});
        pdx   = dx0_reg * dx0_reg;
        pdy   = dy0_reg * dy0_reg;
        pii   = inner * inner;
        dvs   = {1'b0, geom.rad} + 13'd1;
        ds1   = vtpp_pkg::div_step(num0_reg, dvs, 2'd2);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            border1_reg <= border0_reg;
            dx2_reg     <= pdx[23:0];
            dy2_reg     <= pdy[23:0];
            rr_reg      <= geom.rad * geom.rad;
            ii_reg      <= pii[23:0];
            n1_reg      <= ds1[15:0];
            q2_reg      <= ds1[16];
        end
    end

    // stage 2: distance compares, second quotient bit
    always_comb
    begin
        d2  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        ds2 = vtpp_pkg::div_step(n1_reg, dvs, 2'd1);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            border2_reg   <= border1_reg;
            in_inner2_reg <= d2 < {1'b0, ii_reg};
            in_disk2_reg  <= d2 < {1'b0, rr_reg};
            n2_reg        <= ds2[15:0];
            q21_reg       <= {q2_reg, ds2[16]};
        end
    end

    // stage 3: last quotient bit gives the stripe index
    always_comb
    begin
        ds3                = vtpp_pkg::div_step(n2_reg, dvs, 2'd0);
        cls3_next.border   = border2_reg;
        cls3_next.in_inner = in_inner2_reg;
        cls3_next.in_disk  = in_disk2_reg;
        cls3_next.sel      = {q21_reg, ds3[16]};
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            cls_reg[3] <= cls3_next;
        for (int k = 4; k <= 6; k++)
            if (en[k])
                cls_reg[k] <= cls_reg[k-1];
    end

    vtpp_rem u_rem_x (
        .clk      (clk),
        .en       (en[6:1]),
        .dividend (adx0_reg),
        .divisor  (geom.grid),
        .rem      (remx)
    );

    vtpp_rem u_rem_y (
        .clk      (clk),
        .en       (en[6:1]),
        .dividend (ady0_reg),
        .divisor  (geom.grid),
        .rem      (remy)
    );

    // stage 7: color select
    always_comb
    begin
        grid_hit = (geom.grid != 11'd0) &&
                   ((remx < {4'd0, geom.t}) || (remy < {4'd0, geom.t}));
        if (cls_reg[6].border)
            color_next = vtpp_pkg::COLOR_GREEN;
        else if (cls_reg[6].in_inner)
            color_next = vtpp_pkg::stripe_color(cls_reg[6].sel);
        else if (cls_reg[6].in_disk)
            color_next = cls_reg[6].sel[0] ? vtpp_pkg::COLOR_WHITE : vtpp_pkg::COLOR_GREY;
        else if (grid_hit)
            color_next = vtpp_pkg::COLOR_RED;
        else
            color_next = vtpp_pkg::COLOR_BLACK;
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
            color_reg <= color_next;
    end

    assign red   = color_reg.r;
    assign green = color_reg.g;
    assign blue  = color_reg.b;

endmodule
